/* sv/trip_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trip_pkg
// Types, codes and constants shared by the tagged-record image parser.
// ----------------------------------------------------------------------------
package trip_pkg;

  localparam int unsigned NameBytes = 32;
  localparam int unsigned HdrBytes  = 44;
  localparam int unsigned MarkLen   = 14;
  localparam int unsigned MinImage  = 2 * HdrBytes;

  // Marker names in ASCII, first character in the top byte; the byte after them is zero.
  localparam logic [8*13-1:0] HeadMark = 104'h5F5F555441475F484541445F5F;
  localparam logic [8*13-1:0] TailMark = 104'h5F5F555441475F5441494C5F5F;

  typedef enum logic [2:0] {
    ROLE_NAME    = 3'd0,
    ROLE_SIZE    = 3'd1,
    ROLE_FLAGS   = 3'd2,
    ROLE_CHECK   = 3'd3,
    ROLE_PAYLOAD = 3'd4,
    ROLE_PAD     = 3'd5,
    ROLE_DONE    = 3'd6
  } role_e;

  typedef enum logic [2:0] {
    ST_PARSING  = 3'd0,
    ST_TAIL_OK  = 3'd1,
    ST_SMALL    = 3'd2,
    ST_BAD_HEAD = 3'd3,
    ST_BAD_TAIL = 3'd4,
    ST_OVERRUN  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    REG_IMAGE_LEN = 2'd0,
    REG_NONE      = 2'd1
  } reg_idx_e;

  typedef struct packed {
    logic [24:0] image_pos;
    logic [24:0] rec_pos;
    logic [24:0] rec_start;
    logic [19:0] rec_count;
    logic [31:0] size_word;
    logic [31:0] flags_word;
    logic        head_match;
    logic        tail_match;
    status_e     status;
  } parse_state_t;

  localparam parse_state_t ParseReset = '{
    image_pos:  25'd0,
    rec_pos:    25'd0,
    rec_start:  25'd0,
    rec_count:  20'd0,
    size_word:  32'd0,
    flags_word: 32'd0,
    head_match: 1'b1,
    tail_match: 1'b1,
    status:     ST_PARSING
  };

  typedef struct packed {
    role_e       byte_role;
    logic [19:0] record_index;
    logic [23:0] field_offset;
    logic [7:0]  byte_value;
    logic [31:0] record_size;
    logic [31:0] record_flags;
    status_e     parse_status;
    logic        image_end;
  } result_t;

  // Byte idx of a marker name; bytes past the text read as zero.
  function automatic logic [7:0] mark_byte(logic [8*13-1:0] mark, logic [3:0] idx);
    logic [7:0] b;
    b = 8'd0;
    for (int i = 0; i < 13; i++) begin
      if (idx == 4'(i)) begin
        b = mark[8*(12-i) +: 8];
      end
    end
    return b;
  endfunction

endpackage
`default_nettype wire

/* sv/trip_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trip_in_if / trip_out_if
// Valid/ready channels carrying image bytes in and tagged bytes out.
// ----------------------------------------------------------------------------
interface trip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface trip_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  byte_role;
  logic [19:0] record_index;
  logic [23:0] field_offset;
  logic [7:0]  byte_value;
  logic [31:0] record_size;
  logic [31:0] record_flags;
  logic [2:0]  parse_status;
  logic        image_end;

  modport source (
    output valid, output byte_role, output record_index, output field_offset,
    output byte_value, output record_size, output record_flags,
    output parse_status, output image_end, input ready
  );
  modport sink (
    input valid, input byte_role, input record_index, input field_offset,
    input byte_value, input record_size, input record_flags,
    input parse_status, input image_end, output ready
  );
endinterface
`default_nettype wire

/* sv/trip_parse.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trip_parse
// One parser step: tags a byte and computes the next parse state.
// ----------------------------------------------------------------------------
module trip_parse
  import trip_pkg::*;
(
  input  parse_state_t st_i,
  input  logic [7:0]   byte_i,
  input  logic [24:0]  bs_i,
  output parse_state_t st_o,
  output result_t      res_o
);

  status_e     status;
  logic [24:0] rp;
  logic [24:0] pay_off;
  logic [33:0] padded;
  logic [33:0] room_need;
  logic        last;

  always_comb begin
    st_o      = st_i;
    res_o     = '{byte_role: ROLE_DONE, record_index: 20'd0, field_offset: 24'd0,
                  byte_value: byte_i, record_size: 32'd0, record_flags: 32'd0,
                  parse_status: ST_PARSING, image_end: 1'b0};
    status    = st_i.status;
    rp        = st_i.rec_pos;
    pay_off   = rp - 25'(HdrBytes);
    padded    = ({2'b0, st_i.size_word} + 34'd3) & ~34'd3;
    room_need = {9'b0, st_i.rec_start} + 34'(2 * HdrBytes) + padded;
    last      = 1'b0;

    if (status == ST_PARSING && bs_i < 25'(MinImage)) begin
      status = ST_SMALL;
    end

    if (status == ST_PARSING) begin
      res_o.record_index = st_i.rec_count;
      if (rp < 25'(NameBytes)) begin
        res_o.byte_role    = ROLE_NAME;
        res_o.field_offset = rp[23:0];
        if (rp < 25'(MarkLen)) begin
          if (byte_i != mark_byte(HeadMark, rp[3:0])) st_o.head_match = 1'b0;
          if (byte_i != mark_byte(TailMark, rp[3:0])) st_o.tail_match = 1'b0;
        end
      end else if (rp < 25'(NameBytes + 4)) begin
        res_o.byte_role    = ROLE_SIZE;
        res_o.field_offset = 24'(rp - 25'(NameBytes));
        st_o.size_word     = {st_i.size_word[23:0], byte_i};
      end else if (rp < 25'(NameBytes + 8)) begin
        res_o.byte_role    = ROLE_FLAGS;
        res_o.field_offset = 24'(rp - 25'(NameBytes + 4));
        st_o.flags_word    = {st_i.flags_word[23:0], byte_i};
      end else if (rp < 25'(HdrBytes)) begin
        res_o.byte_role    = ROLE_CHECK;
        res_o.field_offset = 24'(rp - 25'(NameBytes + 8));
      end else if ({7'b0, pay_off} < st_i.size_word) begin
        res_o.byte_role    = ROLE_PAYLOAD;
        res_o.field_offset = pay_off[23:0];
      end else begin
        res_o.byte_role    = ROLE_PAD;
        res_o.field_offset = pay_off[23:0] - st_i.size_word[23:0];
      end
      res_o.record_size  = (rp >= 25'(NameBytes + 3)) ? st_o.size_word : 32'd0;
      res_o.record_flags = (rp >= 25'(NameBytes + 7)) ? st_o.flags_word : 32'd0;

      // Header complete: head, then tail, then room for the next header.
      if (rp == 25'(HdrBytes - 1)) begin
        if (st_i.rec_count == 20'd0 &&
            (!st_i.head_match || st_i.size_word != 32'd0)) begin
          status = ST_BAD_HEAD;
        end else if (st_i.tail_match) begin
          status = (st_i.size_word != 32'd0) ? ST_BAD_TAIL : ST_TAIL_OK;
        end else if (room_need > {9'b0, bs_i}) begin
          status = ST_OVERRUN;
        end
        last = (status == ST_PARSING) && (padded == 34'd0);
      end else if (rp >= 25'(HdrBytes) && ({9'b0, pay_off} + 34'd1) == padded) begin
        last = 1'b1;
      end

      if (last) begin
        st_o.rec_pos    = 25'd0;
        st_o.rec_start  = st_i.image_pos + 25'd1;
        st_o.size_word  = 32'd0;
        st_o.flags_word = 32'd0;
        st_o.head_match = 1'b1;
        st_o.tail_match = 1'b1;
        st_o.rec_count  = st_i.rec_count + 20'd1;
      end else if (status == ST_PARSING) begin
        st_o.rec_pos = rp + 25'd1;
      end
    end

    st_o.status        = status;
    res_o.parse_status = status;

    // Last byte of the image: restart everything for the next one.
    if ({1'b0, st_i.image_pos} + 26'd1 >= {1'b0, bs_i}) begin
      res_o.image_end = 1'b1;
      st_o            = ParseReset;
    end else begin
      st_o.image_pos = st_i.image_pos + 25'd1;
    end
  end

endmodule
`default_nettype wire

/* sv/trip_outq.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trip_outq
// Two-entry result queue; keeps the input side moving while the sink stalls, until both entries are full.
// ----------------------------------------------------------------------------
module trip_outq
  import trip_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  output logic    ready_o,
  output logic    valid_o,
  input  logic    pop_ready_i,
  output result_t data_o
);

  logic [1:0] cnt_q, cnt_d;
  result_t    slot0_q, slot1_q;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign ready_o = (cnt_q != 2'd2);
  assign data_o  = slot0_q;
  assign pop     = valid_o && pop_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) cnt_d = cnt_q + 2'd1;
    if (!push_i && pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      // Advance the second entry, or take the new item straight into the head.
      if (cnt_q == 2'd2) begin
        slot0_q <= slot1_q;
      end else if (push_i) begin
        slot0_q <= data_i;
      end
    end else if (push_i) begin
      if (cnt_q == 2'd0) begin
        slot0_q <= data_i;
      end else begin
        slot1_q <= data_i;
      end
    end
  end

endmodule
`default_nettype wire

/* sv/tagged_record_image_parser_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tagged_record_image_parser_core
// Tags each byte of a record image with role, record, offset and status.
// ----------------------------------------------------------------------------
// The result of a byte is registered into the output queue as the byte is accepted.
// Throughput: one byte per cycle while the output queue has room; the parse step
// is a single pass of counters and compares on the parse state register.
// A two-entry output queue keeps input accepted while the result sink stalls, until it is full.
// Reset clears the parse state, the output queue and the image length (to zero).
// ----------------------------------------------------------------------------
module tagged_record_image_parser_core
  import trip_pkg::*;
#(
  parameter longint unsigned MAX_IMAGE_BYTES = 16777216
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  trip_in_if.sink            item_i,
  trip_out_if.source         result_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [32:0] MaxBytes = 33'(MAX_IMAGE_BYTES);

  logic [24:0]  img_len_q;
  logic [24:0]  bs;
  reg_idx_e     reg_idx;
  parse_state_t st_q, st_d;
  result_t      res, head;
  logic         accept;
  logic         q_ready;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_idx = (paddr[2] == 1'b0) ? REG_IMAGE_LEN : REG_NONE;

  always_comb begin
    unique case (reg_idx)
      REG_IMAGE_LEN: prdata = {7'b0, img_len_q};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_len_q <= 25'd0;
    end else if (psel && penable && pwrite && reg_idx == REG_IMAGE_LEN) begin
      img_len_q <= pwdata[24:0];
    end
  end

  assign bs = ({8'b0, img_len_q} > MaxBytes) ? MaxBytes[24:0] : img_len_q;

  // Parse step
  assign accept       = item_i.valid && q_ready;
  assign item_i.ready = q_ready;

  trip_parse u_parse (
    .st_i   (st_q),
    .byte_i (item_i.data_byte),
    .bs_i   (bs),
    .st_o   (st_d),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ParseReset;
    end else if (accept) begin
      st_q <= st_d;
    end
  end

  trip_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .data_i      (res),
    .ready_o     (q_ready),
    .valid_o     (result_o.valid),
    .pop_ready_i (result_o.ready),
    .data_o      (head)
  );

  assign result_o.byte_role    = head.byte_role;
  assign result_o.record_index = head.record_index;
  assign result_o.field_offset = head.field_offset;
  assign result_o.byte_value   = head.byte_value;
  assign result_o.record_size  = head.record_size;
  assign result_o.record_flags = head.record_flags;
  assign result_o.parse_status = head.parse_status;
  assign result_o.image_end    = head.image_end;

  // Checks
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && res.image_end |=> st_q.image_pos == 25'd0 && st_q.rec_count == 20'd0)
    else $error("parse state not restarted after image end");

  // Record position freezes once parsing stops, so only track it while parsing
  a_rec_in_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.status == ST_PARSING |-> st_q.rec_start + st_q.rec_pos == st_q.image_pos)
    else $error("record position out of step with image position");

  a_done_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.byte_role == ROLE_DONE |->
      result_o.record_index == 20'd0 && result_o.record_size == 32'd0 &&
      result_o.record_flags == 32'd0)
    else $error("byte past end carries record fields");

  a_full_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item_i.ready |-> result_o.valid)
    else $error("input stalled with empty result queue");

endmodule
`default_nettype wire

/* tb/tagged_record_image_parser_core_tb.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tagged_record_image_parser_core_tb
// Streams record images into the parser one byte per item and checks every
// tagged byte against a cycle-free prediction of the parse. Images are mostly
// chains of well-formed records with random content. Each image but a good one
// takes one of the failure paths (bad head, bad tail, missing tail, overrun,
// noise), and the image length is swept through zero, the small-image edge and
// the widest value.
// ----------------------------------------------------------------------------
module tagged_record_image_parser_core_tb;
  import trip_pkg::*;

  localparam longint unsigned MaxImageBytes = 64'd16777216;

  typedef enum int unsigned {
    IMG_GOOD,
    IMG_OVERRUN,
    IMG_BAD_TAIL,
    IMG_NO_TAIL,
    IMG_BAD_HEAD_NAME,
    IMG_BAD_HEAD_SIZE,
    IMG_NOISE
  } image_kind_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  trip_in_if  in_if ();
  trip_out_if out_if ();

  tagged_record_image_parser_core #(
    .MAX_IMAGE_BYTES(MaxImageBytes)
  ) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (in_if),
    .result_o (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #6 clk_i = ~clk_i;

  logic [7:0]  pending_bytes[$];
  logic [7:0]  image_bytes[$];
  result_t     expected_tags[$];
  int unsigned mismatch_count = 0;
  int unsigned source_idle_pct = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned sink_hold_cycles = 0;

  // Parser state as the block should hold it
  logic [24:0]     cfg_image_len;
  longint unsigned image_offset;
  longint unsigned record_offset;
  logic [19:0]     record_number;
  logic [31:0]     size_shift;
  logic [31:0]     flags_shift;
  logic            head_name_ok;
  logic            tail_name_ok;
  status_e         parser_status;

  function automatic void begin_record();
    record_offset = 0;
    size_shift    = '0;
    flags_shift   = '0;
    head_name_ok  = 1'b1;
    tail_name_ok  = 1'b1;
  endfunction

  function automatic void begin_image();
    image_offset  = 0;
    record_number = '0;
    parser_status = ST_PARSING;
    begin_record();
  endfunction

  function automatic result_t tag_byte(logic [7:0] b);
    result_t         r;
    longint unsigned bs;
    longint unsigned rp;
    longint unsigned sz;
    longint unsigned padded;
    longint unsigned rec_start;
    int              ci;
    logic [7:0]      head_ch;
    logic [7:0]      tail_ch;
    bit              last;
    r = '0;
    r.byte_role = ROLE_DONE;
    r.byte_value = b;
    last = 1'b0;
    bs = cfg_image_len;
    if (bs > MaxImageBytes) begin
      bs = MaxImageBytes;
    end
    if (parser_status == ST_PARSING && bs < MinImage) begin
      parser_status = ST_SMALL;
    end
    if (parser_status == ST_PARSING) begin
      rp = record_offset;
      sz = size_shift;
      r.record_index = record_number;
      if (rp < NameBytes) begin
        r.byte_role = ROLE_NAME;
        r.field_offset = 24'(rp);
        if (rp < MarkLen) begin
          ci = int'(rp);
          if (ci < MarkLen - 1) begin
            head_ch = HeadMark[8*(12-ci) +: 8];
            tail_ch = TailMark[8*(12-ci) +: 8];
          end else begin
            head_ch = 8'h00;
            tail_ch = 8'h00;
          end
          if (b != head_ch) head_name_ok = 1'b0;
          if (b != tail_ch) tail_name_ok = 1'b0;
        end
      end else if (rp < NameBytes + 4) begin
        r.byte_role = ROLE_SIZE;
        r.field_offset = 24'(rp - NameBytes);
        size_shift = {size_shift[23:0], b};
      end else if (rp < NameBytes + 8) begin
        r.byte_role = ROLE_FLAGS;
        r.field_offset = 24'(rp - NameBytes - 4);
        flags_shift = {flags_shift[23:0], b};
      end else if (rp < HdrBytes) begin
        r.byte_role = ROLE_CHECK;
        r.field_offset = 24'(rp - NameBytes - 8);
      end else if (rp < HdrBytes + sz) begin
        r.byte_role = ROLE_PAYLOAD;
        r.field_offset = 24'(rp - HdrBytes);
      end else begin
        r.byte_role = ROLE_PAD;
        r.field_offset = 24'(rp - HdrBytes - sz);
      end
      if (rp >= NameBytes + 3) r.record_size = size_shift;
      if (rp >= NameBytes + 7) r.record_flags = flags_shift;

      // Header complete: judge head, then tail, then room for the next header
      if (rp == HdrBytes - 1) begin
        sz = size_shift;
        padded = (sz + 3) & ~64'd3;
        if (record_number == 0 && (!head_name_ok || size_shift != 0)) begin
          parser_status = ST_BAD_HEAD;
        end else if (tail_name_ok) begin
          parser_status = (size_shift != 0) ? ST_BAD_TAIL : ST_TAIL_OK;
        end else begin
          rec_start = image_offset - rp;
          if (rec_start + HdrBytes + padded + HdrBytes > bs) begin
            parser_status = ST_OVERRUN;
          end
        end
        last = (parser_status == ST_PARSING) && (padded == 0);
      end else if (rp >= HdrBytes && rp == HdrBytes - 1 + ((sz + 3) & ~64'd3)) begin
        last = 1'b1;
      end

      if (last) begin
        begin_record();
        record_number = record_number + 20'd1;
      end else if (parser_status == ST_PARSING) begin
        record_offset = rp + 1;
      end
    end
    r.parse_status = parser_status;
    if (image_offset + 1 >= bs) begin
      r.image_end = 1'b1;
      begin_image();
    end else begin
      image_offset = image_offset + 1;
    end
    return r;
  endfunction

  function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  // Byte source: hold the item until taken, predict on acceptance
  always @(posedge clk_i) begin : byte_source
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data_byte <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_tags.push_back(tag_byte(in_if.data_byte));
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= source_idle_pct) begin
          in_if.valid <= 1'b1;
          in_if.data_byte <= pending_bytes.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : hold_counter
    if (sink_hold_cycles != 0) sink_hold_cycles <= sink_hold_cycles - 1;
  end

  always @(posedge clk_i) begin : tag_sink
    result_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_tags.size() == 0) begin
          $display("%0t ns: unexpected tagged byte, expected none, actual value 0x%0h",
                   $time, out_if.byte_value);
          mismatch_count++;
        end else begin
          want = expected_tags.pop_front();
          compare_field("byte_role", 32'(want.byte_role), 32'(out_if.byte_role));
          compare_field("record_index", 32'(want.record_index), 32'(out_if.record_index));
          compare_field("field_offset", 32'(want.field_offset), 32'(out_if.field_offset));
          compare_field("byte_value", 32'(want.byte_value), 32'(out_if.byte_value));
          compare_field("record_size", want.record_size, out_if.record_size);
          compare_field("record_flags", want.record_flags, out_if.record_flags);
          compare_field("parse_status", 32'(want.parse_status), 32'(out_if.parse_status));
          compare_field("image_end", 32'(want.image_end), 32'(out_if.image_end));
        end
      end
      if (sink_hold_cycles != 0) begin
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  task automatic write_register(reg_idx_e idx, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_IMAGE_LEN) cfg_image_len = 25'(value);
  endtask

  task automatic wait_for_results();
    while (pending_bytes.size() != 0 || in_if.valid || expected_tags.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (3) @(posedge clk_i);
  endtask

  task automatic add_word(logic [31:0] w);
    for (int i = 3; i >= 0; i--) image_bytes.push_back(w[8*i +: 8]);
  endtask

  task automatic add_record(bit marked, logic [8*13-1:0] mark, logic [31:0] size,
                            bit with_body);
    for (int i = 0; i < NameBytes; i++) begin
      if (marked && i < MarkLen - 1) begin
        image_bytes.push_back(mark[8*(12-i) +: 8]);
      end else if (marked && i == MarkLen - 1) begin
        image_bytes.push_back(8'h00);
      end else begin
        image_bytes.push_back(8'($urandom));
      end
    end
    add_word(size);
    add_word($urandom);
    add_word($urandom);
    if (with_body) begin
      for (int unsigned i = 0; i < size; i++) image_bytes.push_back(8'($urandom));
      for (int unsigned i = size; i % 4 != 0; i++) image_bytes.push_back(8'h00);
    end
  endtask

  task automatic build_image(image_kind_e kind, int unsigned bs, int unsigned fill_to);
    int unsigned pos;
    int unsigned room;
    int unsigned size;
    int unsigned mid_count;
    image_bytes.delete();
    if (kind != IMG_NOISE) begin
      add_record(1'b1, HeadMark, (kind == IMG_BAD_HEAD_SIZE) ? 1 + $urandom_range(7) : 0, 1'b1);
      if (kind == IMG_BAD_HEAD_NAME) begin
        pos = $urandom_range(MarkLen - 1);
        image_bytes[pos] = image_bytes[pos] ^ 8'(1 + $urandom_range(254));
      end
      // Keep each middle record small enough to leave room for the next header
      mid_count = $urandom_range(3);
      for (int m = 0; m < mid_count; m++) begin
        pos = image_bytes.size();
        if (bs < pos + 2 * HdrBytes) break;
        room = (bs - pos - 2 * HdrBytes) & ~32'd3;
        if (room > 24) begin
          size = $urandom_range(24);
        end else begin
          size = ($urandom_range(3) == 0) ? room : $urandom_range(room);
        end
        add_record(1'b0, HeadMark, size, 1'b1);
      end
      pos = image_bytes.size();
      case (kind)
        IMG_OVERRUN: begin
          room = (bs > pos + 2 * HdrBytes) ? bs - pos - 2 * HdrBytes : 0;
          if ($urandom_range(1) == 0) size = 32'hFFFF_FFFF - $urandom_range(3);
          else size = room + 1 + $urandom_range(7);
          add_record(1'b0, HeadMark, size, 1'b0);
        end
        IMG_BAD_TAIL: begin
          add_record(1'b1, TailMark, 1 + $urandom_range(15), 1'b0);
        end
        IMG_NO_TAIL: begin
          // Tail name with a nonzero terminator is an ordinary record
          add_record(1'b1, TailMark, 0, 1'b1);
          image_bytes[pos + MarkLen - 1] = 8'(1 + $urandom_range(254));
        end
        default: begin
          add_record(1'b1, TailMark, 0, 1'b1);
        end
      endcase
    end
    while (image_bytes.size() < fill_to) image_bytes.push_back(8'($urandom));
    while (image_bytes.size() > fill_to) void'(image_bytes.pop_back());
  endtask

  task automatic run_image(image_kind_e kind, logic [31:0] reg_value, int unsigned fill_to,
                           int unsigned hold);
    int unsigned bs;
    bs = reg_value[24:0];
    if (bs > MaxImageBytes) bs = int'(MaxImageBytes);
    write_register(REG_IMAGE_LEN, reg_value);
    build_image(kind, bs, fill_to);
    if (hold != 0) begin
      @(negedge clk_i);
      sink_hold_cycles = hold;
    end
    foreach (image_bytes[i]) pending_bytes.push_back(image_bytes[i]);
    wait_for_results();
  endtask

  initial begin : stimulus
    int unsigned bs;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    out_if.ready = 1'b0;
    cfg_image_len = '0;
    begin_image();
    source_idle_pct = 17;
    sink_idle_pct = 55;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Zero size: every byte is an image of its own
    run_image(IMG_NOISE, 32'h0000_0000, 4, 0);
    // One short of the minimum, then drop to zero in the middle of the image
    run_image(IMG_NOISE, {7'h7F, 25'd87}, 3, 0);
    run_image(IMG_NOISE, 32'h0000_0000, 1, 0);
    // Widest value clamps; cut the image short by shrinking the image length
    run_image(IMG_GOOD, 32'hFFFF_FFFF, 60, 0);
    run_image(IMG_NOISE, 32'd48, 1, 0);

    for (int n = 0; n < 7; n++) begin
      if (n == 2) begin
        source_idle_pct = 55;
        sink_idle_pct = 17;
      end else if (n == 4) begin
        source_idle_pct = 0;
        sink_idle_pct = 0;
      end
      bs = (n == 0) ? 88 : (n == 6) ? 24 : 88 + $urandom_range(4);
      // For the bad-head-name image, hold the result side off while bytes keep coming
      run_image(image_kind_e'(n), {7'($urandom_range(127)), 25'(bs)}, bs,
                (n == 4) ? 150 : 0);
    end

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
sv/trip_pkg.sv
sv/trip_if.sv
sv/trip_parse.sv
sv/trip_outq.sv
sv/tagged_record_image_parser_core.sv
tb/tagged_record_image_parser_core_tb.sv
